// File: rtl/core/evi_pkg.sv
// ----------------------------------------------------------------------------
// Eased vector interpolator package
// Shared widths, operation and easing codes, and the controller/datapath
// command and status words.
// ----------------------------------------------------------------------------
package evi_pkg;

   localparam int EVI_POS_WIDTH  = 32;
   localparam int EVI_TIME_WIDTH = 16;

   // Q0.16 fraction, 1.0 included, so one extra bit
   localparam int FRAC_BITS = 16;
   localparam int FRAC_W    = FRAC_BITS + 1;

   // shared unsigned multiplier
   localparam int MUL_W  = 18;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_FORCE = 2'd2;

   localparam logic [1:0] EASE_LINEAR   = 2'd0;
   localparam logic [1:0] EASE_QUAD_OUT = 2'd1;
   localparam logic [1:0] EASE_QUAD_IN  = 2'd2;
   localparam logic [1:0] EASE_IN_OUT   = 2'd3;

   typedef struct packed {
      logic capture;
      logic div_init;
      logic div_step;
      logic ease_mul;
      logic ease_fin;
      logic axis_init;
      logic mul_chunk;
      logic acc_chunk;
      logic axis_write;
      logic tick_commit;
      logic do_start;
      logic do_force;
      logic clr_running;
      logic rsp_load;
   } evi_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       in_range;
      logic       running;
      logic       div_last;
      logic       chunk_last;
      logic       axis_last;
   } evi_sts_type;

endpackage

// File: rtl/core/evi_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation word with its operands.
// ----------------------------------------------------------------------------
interface evi_req_if #(
   parameter int POS_WIDTH  = 32,
   parameter int TIME_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic signed [POS_WIDTH-1:0]  start_x;
   logic signed [POS_WIDTH-1:0]  start_y;
   logic signed [POS_WIDTH-1:0]  start_z;
   logic signed [POS_WIDTH-1:0]  end_x;
   logic signed [POS_WIDTH-1:0]  end_y;
   logic signed [POS_WIDTH-1:0]  end_z;
   logic [TIME_WIDTH-1:0]        duration;
   logic [TIME_WIDTH-1:0]        delta_time;

   modport source (
      output valid, operation, start_x, start_y, start_z, end_x, end_y, end_z,
             duration, delta_time,
      input  ready
   );

   modport sink (
      input  valid, operation, start_x, start_y, start_z, end_x, end_y, end_z,
             duration, delta_time,
      output ready
   );
endinterface

// File: rtl/core/evi_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the position and active flag after one word.
// ----------------------------------------------------------------------------
interface evi_rsp_if #(
   parameter int POS_WIDTH = 32
);
   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] pos_x;
   logic signed [POS_WIDTH-1:0] pos_y;
   logic signed [POS_WIDTH-1:0] pos_z;
   logic                        active;

   modport source (
      output valid, pos_x, pos_y, pos_z, active,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, pos_z, active,
      output ready
   );
endinterface

// File: rtl/core/evi_ctrl.sv
// ----------------------------------------------------------------------------
// Interpolator controller
// Sequences decode, division, easing and per-axis blending, and owns the
// request ready and response valid handshakes.
// ----------------------------------------------------------------------------
module evi_ctrl
   import evi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  evi_sts_type sts,
   output evi_cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_DIV      = 4'd2;
   localparam logic [3:0] S_EASE_MUL = 4'd3;
   localparam logic [3:0] S_EASE_FIN = 4'd4;
   localparam logic [3:0] S_AXIS     = 4'd5;
   localparam logic [3:0] S_MUL      = 4'd6;
   localparam logic [3:0] S_ACC      = 4'd7;
   localparam logic [3:0] S_WRITE    = 4'd8;
   localparam logic [3:0] S_RESP     = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            unique case (sts.op)
               OP_TICK: begin
                  if (sts.in_range) begin
                     cmd.div_init = 1'b1;
                     state_in     = S_DIV;
                  end else begin
                     cmd.clr_running = 1'b1;
                  end
               end
               OP_START: cmd.do_start = ~sts.running;
               OP_FORCE: cmd.do_force = 1'b1;
               default: ;
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_EASE_MUL;
            end
         end
         S_EASE_MUL: begin
            cmd.ease_mul = 1'b1;
            state_in     = S_EASE_FIN;
         end
         S_EASE_FIN: begin
            cmd.ease_fin = 1'b1;
            state_in     = S_AXIS;
         end
         S_AXIS: begin
            cmd.axis_init = 1'b1;
            state_in      = S_MUL;
         end
         S_MUL: begin
            cmd.mul_chunk = 1'b1;
            state_in      = S_ACC;
         end
         S_ACC: begin
            cmd.acc_chunk = 1'b1;
            state_in      = sts.chunk_last ? S_WRITE : S_MUL;
         end
         S_WRITE: begin
            cmd.axis_write = 1'b1;
            if (sts.axis_last) begin
               cmd.tick_commit = 1'b1;
               state_in        = S_RESP;
            end else begin
               state_in = S_AXIS;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/evi_datapath.sv
// ----------------------------------------------------------------------------
// Interpolator datapath
// Holds the interpolation state, a restoring divider for the elapsed
// fraction, one shared 18x18 multiplier for easing and chunked blending,
// and the response word register.
// ----------------------------------------------------------------------------
module evi_datapath
   import evi_pkg::*;
#(
   parameter int POS_WIDTH  = EVI_POS_WIDTH,
   parameter int TIME_WIDTH = EVI_TIME_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  evi_cmd_type                 cmd,
   output evi_sts_type                 sts,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_wr_data,
   input  logic [1:0]                  req_operation,
   input  logic signed [POS_WIDTH-1:0] req_start_x,
   input  logic signed [POS_WIDTH-1:0] req_start_y,
   input  logic signed [POS_WIDTH-1:0] req_start_z,
   input  logic signed [POS_WIDTH-1:0] req_end_x,
   input  logic signed [POS_WIDTH-1:0] req_end_y,
   input  logic signed [POS_WIDTH-1:0] req_end_z,
   input  logic [TIME_WIDTH-1:0]       req_duration,
   input  logic [TIME_WIDTH-1:0]       req_delta_time,
   output logic signed [POS_WIDTH-1:0] rsp_pos_x,
   output logic signed [POS_WIDTH-1:0] rsp_pos_y,
   output logic signed [POS_WIDTH-1:0] rsp_pos_z,
   output logic                        rsp_active
);

   localparam int EL_W      = TIME_WIDTH + 1;
   localparam int DIFF_W    = POS_WIDTH + 1;
   localparam int CHUNKS    = (DIFF_W + FRAC_BITS - 1) / FRAC_BITS;
   localparam int MAG_W     = CHUNKS * FRAC_BITS;
   localparam int CNT_W     = $clog2(CHUNKS);
   localparam int ACC_W     = MAG_W + FRAC_W;
   localparam int DIV_CNT_W = $clog2(FRAC_W);

   localparam logic [FRAC_W-1:0] ONE_Q  = FRAC_W'(1) << FRAC_BITS;
   localparam logic [FRAC_W-1:0] HALF_Q = FRAC_W'(1) << (FRAC_BITS - 1);
   localparam logic [MUL_W-1:0]  ONE_M  = MUL_W'(1) << FRAC_BITS;
   localparam logic [MUL_W-1:0]  TWO_M  = MUL_W'(1) << (FRAC_BITS + 1);
   localparam logic [PROD_W:0]   ONE_SQ = (PROD_W + 1)'(1) << (2 * FRAC_BITS);
   localparam logic [ACC_W-1:0]  ROUND  = ACC_W'((1 << FRAC_BITS) - 1);

   // configuration and latched request word
   logic [1:0]            ease_mode_ff, ease_mode_in;
   logic [1:0]            op_ff, op_in;
   logic [POS_WIDTH-1:0]  start_ff [3];
   logic [POS_WIDTH-1:0]  start_in [3];
   logic [POS_WIDTH-1:0]  end_ff [3];
   logic [POS_WIDTH-1:0]  end_in [3];
   logic [TIME_WIDTH-1:0] dur_ff, dur_in;
   logic [TIME_WIDTH-1:0] delta_ff, delta_in;

   // interpolation state
   logic [EL_W-1:0]       elapsed_ff, elapsed_in;
   logic [TIME_WIDTH-1:0] run_len_ff, run_len_in;
   logic [POS_WIDTH-1:0]  origin_ff [3];
   logic [POS_WIDTH-1:0]  origin_in [3];
   logic [POS_WIDTH-1:0]  target_ff [3];
   logic [POS_WIDTH-1:0]  target_in [3];
   logic [POS_WIDTH-1:0]  current_ff [3];
   logic [POS_WIDTH-1:0]  current_in [3];
   logic                  running_ff, running_in;

   // divider, easing, blending
   logic [EL_W-1:0]      rem_ff, rem_in;
   logic [FRAC_W-1:0]    quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic                 half_ff, half_in;
   logic [FRAC_W-1:0]    e_ff, e_in;
   logic [1:0]           axis_ff, axis_in;
   logic                 neg_ff, neg_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     chunk_ff, chunk_in;

   // response word
   logic [POS_WIDTH-1:0] rsp_pos_ff [3];
   logic [POS_WIDTH-1:0] rsp_pos_in [3];
   logic                 rsp_active_ff, rsp_active_in;

   logic [FRAC_W-1:0]    frac;
   logic                 rem_ge;
   logic [EL_W-1:0]      rem_sub;
   logic [MUL_W-1:0]     f_m, u_m, ease_a, ease_b, mul_a, mul_b;
   logic                 f_half;
   logic [PROD_W:0]      in_out_sum;
   logic [POS_WIDTH-1:0] origin_sel, target_sel;
   logic [DIFF_W-1:0]    diff, diff_abs;
   logic [ACC_W-1:0]     acc_round;
   logic [POS_WIDTH-1:0] q_mag, pos_new;

   assign frac    = (run_len_ff == '0) ? ONE_Q : quot_ff;
   assign rem_ge  = rem_ff >= {1'b0, run_len_ff};
   assign rem_sub = rem_ge ? rem_ff - {1'b0, run_len_ff} : rem_ff;

   assign f_m    = {1'b0, frac};
   assign u_m    = {frac, 1'b0} - ONE_M;
   assign f_half = frac < HALF_Q;

   always_comb begin
      unique case (ease_mode_ff)
         EASE_QUAD_OUT: begin
            ease_a = f_m;
            ease_b = TWO_M - f_m;
         end
         EASE_IN_OUT: begin
            ease_a = f_half ? f_m : u_m;
            ease_b = f_half ? f_m : TWO_M - u_m;
         end
         default: begin
            ease_a = f_m;
            ease_b = f_m;
         end
      endcase
   end

   assign mul_a = cmd.mul_chunk ? MUL_W'(mag_ff[chunk_ff*FRAC_BITS +: FRAC_BITS]) : ease_a;
   assign mul_b = cmd.mul_chunk ? MUL_W'(e_ff) : ease_b;

   assign in_out_sum = {1'b0, prod_ff} + ONE_SQ;

   assign origin_sel = origin_ff[axis_ff];
   assign target_sel = target_ff[axis_ff];
   assign diff       = {target_sel[POS_WIDTH-1], target_sel}
                     - {origin_sel[POS_WIDTH-1], origin_sel};
   assign diff_abs   = diff[DIFF_W-1] ? -diff : diff;

   // floor of the signed product: round the magnitude up when negative
   assign acc_round = neg_ff ? acc_ff + ROUND : acc_ff;
   assign q_mag     = acc_round[FRAC_BITS +: POS_WIDTH];
   assign pos_new   = neg_ff ? origin_sel - q_mag : origin_sel + q_mag;

   always_comb begin
      ease_mode_in  = csr_wr_en ? csr_wr_data : ease_mode_ff;
      op_in         = op_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      dur_in        = dur_ff;
      delta_in      = delta_ff;
      elapsed_in    = elapsed_ff;
      run_len_in    = run_len_ff;
      origin_in     = origin_ff;
      target_in     = target_ff;
      current_in    = current_ff;
      running_in    = running_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      div_cnt_in    = div_cnt_ff;
      prod_in       = prod_ff;
      half_in       = half_ff;
      e_in          = e_ff;
      axis_in       = axis_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      acc_in        = acc_ff;
      chunk_in      = chunk_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_active_in = rsp_active_ff;

      if (cmd.capture) begin
         op_in       = req_operation;
         start_in[0] = req_start_x;
         start_in[1] = req_start_y;
         start_in[2] = req_start_z;
         end_in[0]   = req_end_x;
         end_in[1]   = req_end_y;
         end_in[2]   = req_end_z;
         dur_in      = req_duration;
         delta_in    = req_delta_time;
      end

      if (cmd.div_init) begin
         rem_in     = elapsed_ff;
         quot_in    = '0;
         div_cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in     = {rem_sub[EL_W-2:0], 1'b0};
         quot_in    = {quot_ff[FRAC_W-2:0], rem_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (cmd.ease_mul || cmd.mul_chunk) begin
         prod_in = mul_a * mul_b;
      end
      if (cmd.ease_mul) begin
         half_in = f_half;
      end
      if (cmd.ease_fin) begin
         axis_in = '0;
         unique case (ease_mode_ff)
            EASE_LINEAR:   e_in = frac;
            EASE_QUAD_OUT: e_in = prod_ff[FRAC_BITS +: FRAC_W];
            EASE_QUAD_IN:  e_in = prod_ff[FRAC_BITS +: FRAC_W];
            EASE_IN_OUT:   e_in = half_ff ? prod_ff[FRAC_BITS-1 +: FRAC_W]
                                          : in_out_sum[FRAC_BITS+1 +: FRAC_W];
            default:       e_in = frac;
         endcase
      end

      if (cmd.axis_init) begin
         neg_in   = diff[DIFF_W-1];
         mag_in   = MAG_W'(diff_abs);
         acc_in   = '0;
         chunk_in = CNT_W'(CHUNKS - 1);
      end
      if (cmd.acc_chunk) begin
         acc_in   = {acc_ff[ACC_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} + ACC_W'(prod_ff);
         chunk_in = chunk_ff - 1'b1;
      end
      if (cmd.axis_write) begin
         current_in[axis_ff] = pos_new;
         axis_in             = axis_ff + 1'b1;
      end
      if (cmd.tick_commit) begin
         elapsed_in = elapsed_ff + EL_W'(delta_ff);
      end

      if (cmd.do_start) begin
         elapsed_in = '0;
         run_len_in = dur_ff;
         origin_in  = start_ff;
         target_in  = end_ff;
         running_in = 1'b1;
      end
      if (cmd.do_force) begin
         elapsed_in = {1'b0, run_len_ff} + 1'b1;
         running_in = 1'b0;
      end
      if (cmd.clr_running) begin
         running_in = 1'b0;
      end

      if (cmd.rsp_load) begin
         rsp_pos_in    = current_ff;
         rsp_active_in = running_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ease_mode_ff <= EASE_LINEAR;
         elapsed_ff   <= EL_W'(1);
         run_len_ff   <= '0;
         origin_ff    <= '{default: '0};
         target_ff    <= '{default: '0};
         current_ff   <= '{default: '0};
         running_ff   <= 1'b0;
      end else begin
         ease_mode_ff <= ease_mode_in;
         elapsed_ff   <= elapsed_in;
         run_len_ff   <= run_len_in;
         origin_ff    <= origin_in;
         target_ff    <= target_in;
         current_ff   <= current_in;
         running_ff   <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      dur_ff        <= dur_in;
      delta_ff      <= delta_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      div_cnt_ff    <= div_cnt_in;
      prod_ff       <= prod_in;
      half_ff       <= half_in;
      e_ff          <= e_in;
      axis_ff       <= axis_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      acc_ff        <= acc_in;
      chunk_ff      <= chunk_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign sts.op         = op_ff;
   assign sts.in_range   = elapsed_ff <= {1'b0, run_len_ff};
   assign sts.running    = running_ff;
   assign sts.div_last   = div_cnt_ff == DIV_CNT_W'(FRAC_W - 1);
   assign sts.chunk_last = chunk_ff == '0;
   assign sts.axis_last  = axis_ff == 2'd2;

   assign rsp_pos_x  = rsp_pos_ff[0];
   assign rsp_pos_y  = rsp_pos_ff[1];
   assign rsp_pos_z  = rsp_pos_ff[2];
   assign rsp_active = rsp_active_ff;

endmodule

// File: rtl/core/eased_vector_interpolator.sv
// ----------------------------------------------------------------------------
// Eased vector interpolator
// Moves a three-axis Q16.16 position from a start point to an end point
// over a set duration along a selectable linear or quadratic easing curve.
//
//   channel   role     handshake        payload
//   req_if    input    valid / ready    operation, start/end xyz, duration,
//                                       delta_time
//   rsp_if    output   valid / ready    pos_x/y/z, active
//   csr       config   csr_wr_en        csr_wr_data (ease mode)
//
// One word is in work at a time; every request word yields one response.
// A tick inside the duration runs 17 divider steps for the elapsed
// fraction, two easing steps, and per axis one setup, one multiply plus one
// accumulate per 16-bit chunk of the difference, and one write. Start, force
// end, and out-of-range ticks skip these steps. Reset is synchronous and
// clears the interpolation state and ease mode; no clearing pass is needed.
// A stalled response holds its register; the next request word is taken
// while it waits, and the following response waits for it to drain.
// ----------------------------------------------------------------------------
module eased_vector_interpolator
   import evi_pkg::*;
#(
   parameter int POS_WIDTH  = EVI_POS_WIDTH,
   parameter int TIME_WIDTH = EVI_TIME_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   evi_req_if.sink     req_if,
   evi_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   evi_cmd_type cmd;
   evi_sts_type sts;

   evi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   evi_datapath #(
      .POS_WIDTH  (POS_WIDTH),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_operation  (req_if.operation),
      .req_start_x    (req_if.start_x),
      .req_start_y    (req_if.start_y),
      .req_start_z    (req_if.start_z),
      .req_end_x      (req_if.end_x),
      .req_end_y      (req_if.end_y),
      .req_end_z      (req_if.end_z),
      .req_duration   (req_if.duration),
      .req_delta_time (req_if.delta_time),
      .rsp_pos_x      (rsp_if.pos_x),
      .rsp_pos_y      (rsp_if.pos_y),
      .rsp_pos_z      (rsp_if.pos_z),
      .rsp_active     (rsp_if.active)
   );

   // one word in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while a word is in work");

   // never overwrite an untaken response word
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response word overwritten");

   // never two state updates in the same cycle
   a_single_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.tick_commit, cmd.do_start, cmd.do_force, cmd.clr_running}))
      else $error("conflicting state updates");

   // a new response follows an accepted word
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !req_if.ready)
      else $error("response loaded while idle");

endmodule
